### hdl/cikp_pkg.sv
package cikp_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned CharW   = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CharW-1:0] CharDot  = 8'h2E;
  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharNine = 8'h39;

  localparam logic [AddrW-1:0] DefaultIpReset   = 32'h0A00_020F;
  localparam logic [AddrW-1:0] DefaultMaskReset = 32'hFFFF_FF00;
  localparam logic [AddrW-1:0] DefaultGwReset   = 32'h0A00_0202;

  localparam logic [CfgIdxW-1:0] CfgDefaultIp   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDefaultMask = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDefaultGw   = 2'd2;

  typedef enum logic [1:0] {
    KEY_IP   = 2'd0,
    KEY_MASK = 2'd1,
    KEY_GW   = 2'd2
  } key_e;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_PARSE  = 3'b010,
    PH_DONE   = 3'b100
  } phase_e;

  typedef struct packed {
    logic             step;
    logic             last;
    logic [CharW-1:0] char_code;
  } lane_in_t;

  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] addr;
  } lane_res_t;

  function automatic logic [2:0] key_len(key_e key);
    logic [2:0] len;
    case (key)
      KEY_MASK: len = 3'd5;
      default:  len = 3'd3;
    endcase
    return len;
  endfunction

  // Character of the key text at a given match position
  function automatic logic [CharW-1:0] key_char(key_e key, logic [2:0] pos);
    logic [CharW-1:0] c;
    c = 8'h00;
    case (key)
      KEY_IP: begin
        case (pos)
          3'd0:    c = 8'h69; // i
          3'd1:    c = 8'h70; // p
          3'd2:    c = 8'h3D; // =
          default: c = 8'h00;
        endcase
      end
      KEY_MASK: begin
        case (pos)
          3'd0:    c = 8'h6D; // m
          3'd1:    c = 8'h61; // a
          3'd2:    c = 8'h73; // s
          3'd3:    c = 8'h6B; // k
          3'd4:    c = 8'h3D; // =
          default: c = 8'h00;
        endcase
      end
      KEY_GW: begin
        case (pos)
          3'd0:    c = 8'h67; // g
          3'd1:    c = 8'h77; // w
          3'd2:    c = 8'h3D; // =
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### hdl/cikp_key_lane.sv
module cikp_key_lane import cikp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  key_e      key_i,
  input  lane_in_t  lane_i,
  output lane_res_t res_o
);

  phase_e           phase_q, phase_d;
  logic [2:0]       pos_q, pos_d;
  logic [1:0]       idx_q, idx_d;
  logic [7:0]       acc_q, acc_d;
  logic             hd_q, hd_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             val_q, val_d;

  logic [2:0]       klen;
  logic             is_digit;
  logic [11:0]      prod;

  assign klen     = key_len(key_i);
  assign is_digit = (lane_i.char_code >= CharZero) && (lane_i.char_code <= CharNine);
  assign prod     = 12'(acc_q) * 12'd10 + 12'(lane_i.char_code[3:0]);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    hd_d    = hd_q;
    addr_d  = addr_q;
    val_d   = val_q;
    res_o   = '0;

    if (lane_i.step) begin
      unique case (phase_q)
        PH_SEARCH: begin
          if ((pos_q < klen) && (lane_i.char_code == key_char(key_i, pos_q))) begin
            pos_d = 3'(pos_q + 3'd1);
          end else begin
            pos_d = (lane_i.char_code == key_char(key_i, 3'd0)) ? 3'd1 : 3'd0;
          end
          if (pos_d >= klen) begin
            phase_d = PH_PARSE;
            idx_d   = 2'd0;
            acc_d   = 8'd0;
            hd_d    = 1'b0;
            addr_d  = '0;
          end
        end
        PH_PARSE: begin
          if (is_digit) begin
            if (prod > 12'd255) begin
              phase_d = PH_DONE;
              val_d   = 1'b0;
            end else begin
              acc_d = prod[7:0];
              hd_d  = 1'b1;
            end
          end else if (!hd_q) begin
            phase_d = PH_DONE;
            val_d   = 1'b0;
          end else if (idx_q == 2'd3) begin
            // any non-digit closes the fourth octet
            phase_d = PH_DONE;
            val_d   = 1'b1;
            addr_d  = {addr_q[AddrW-9:0], acc_q};
          end else if (lane_i.char_code != CharDot) begin
            phase_d = PH_DONE;
            val_d   = 1'b0;
          end else begin
            addr_d = {addr_q[AddrW-9:0], acc_q};
            idx_d  = 2'(idx_q + 2'd1);
            acc_d  = 8'd0;
            hd_d   = 1'b0;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      if (lane_i.last) begin
        // end of string closes a pending parse
        if (phase_d == PH_PARSE) begin
          res_o.valid = (idx_d == 2'd3) && hd_d;
          res_o.addr  = {addr_d[AddrW-9:0], acc_d};
        end else begin
          res_o.valid = val_d;
          res_o.addr  = addr_d;
        end
        phase_d = PH_SEARCH;
        pos_d   = 3'd0;
        idx_d   = 2'd0;
        acc_d   = 8'd0;
        hd_d    = 1'b0;
        addr_d  = '0;
        val_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      pos_q   <= 3'd0;
      idx_q   <= 2'd0;
      acc_q   <= 8'd0;
      hd_q    <= 1'b0;
      addr_q  <= '0;
      val_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      hd_q    <= hd_d;
      addr_q  <= addr_d;
      val_q   <= val_d;
    end
  end

`ifndef ASSERT_OFF
  a_search_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SEARCH |-> !val_q && idx_q == 2'd0)
    else $error("search phase with stale parse state");

  a_valid_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    val_q |-> phase_q == PH_DONE)
    else $error("address marked valid outside done phase");

  a_empty_octet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PARSE && !hd_q |-> acc_q == 8'd0)
    else $error("octet accumulator nonzero without digits");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_i.step && lane_i.last |=> phase_q == PH_SEARCH && pos_q == 3'd0)
    else $error("lane not cleared after end of string");
`endif

endmodule

### hdl/cmdline_ipv4_key_parser.sv
// Path: a transaction carrying the last character passes the input register, then the result
//   register, which loads it only once that register is free.
// Throughput: one character per cycle; three key lanes work on each character in parallel.
// While a result waits to be taken, the input side stays free except for a last character.
// Reset (rst_ni low, asynchronous): parser state clears and the default
//   registers load their reset addresses.
module cmdline_ipv4_key_parser import cikp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CharW-1:0]   char_code_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [AddrW-1:0]   ip_address_o,
  output logic [AddrW-1:0]   net_mask_o,
  output logic [AddrW-1:0]   gateway_address_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AddrW-1:0]   cfg_data_i
);

  logic             in_valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             out_valid_q;
  logic [AddrW-1:0] ip_q, mask_q, gw_q;
  logic [AddrW-1:0] def_ip_q, def_mask_q, def_gw_q;

  logic      out_free;
  logic      advance;
  lane_in_t  lane_in;
  lane_res_t res_ip, res_mask, res_gw;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!last_q || out_free);
  assign in_ready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  assign lane_in.step      = advance;
  assign lane_in.last      = last_q;
  assign lane_in.char_code = char_q;

  cikp_key_lane u_lane_ip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (KEY_IP),
    .lane_i (lane_in),
    .res_o  (res_ip)
  );

  cikp_key_lane u_lane_mask (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (KEY_MASK),
    .lane_i (lane_in),
    .res_o  (res_mask)
  );

  cikp_key_lane u_lane_gw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (KEY_GW),
    .lane_i (lane_in),
    .res_o  (res_gw)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_code_i;
      last_q <= last_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      ip_q   <= res_ip.valid   ? res_ip.addr   : def_ip_q;
      mask_q <= res_mask.valid ? res_mask.addr : def_mask_q;
      gw_q   <= res_gw.valid   ? res_gw.addr   : def_gw_q;
    end
  end

  // Default address registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_ip_q   <= DefaultIpReset;
      def_mask_q <= DefaultMaskReset;
      def_gw_q   <= DefaultGwReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDefaultIp:   def_ip_q   <= cfg_data_i;
        CfgDefaultMask: def_mask_q <= cfg_data_i;
        CfgDefaultGw:   def_gw_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ip_address_o      = ip_q;
  assign net_mask_o        = mask_q;
  assign gateway_address_o = gw_q;

endmodule

### tb/key_parser_checker.sv
`timescale 1ns / 100ps

module key_parser_checker import cikp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [CharW-1:0]   char_code_i,
  input  logic               last_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [AddrW-1:0]   ip_address_i,
  input  logic [AddrW-1:0]   net_mask_i,
  input  logic [AddrW-1:0]   gateway_address_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AddrW-1:0]   cfg_data_i,
  output int unsigned        mismatch_cnt_o,
  output int unsigned        pending_o,
  output int unsigned        addr_sets_o,
  output int unsigned        chars_o
);

  localparam int NumKeys   = 3;
  localparam int OctetMax  = 255;
  // Key words right-aligned in 40 bits, first character highest
  localparam logic [NumKeys-1:0][39:0] KeyText = {{16'h0, "gw="}, "mask=", {16'h0, "ip="}};
  localparam logic [NumKeys-1:0][2:0]  KeyLen  = {3'd3, 3'd5, 3'd3};

  typedef struct packed {
    logic [AddrW-1:0] ip;
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] gw;
  } addr_set_t;

  logic [AddrW-1:0] fallback_addr [NumKeys];
  logic [2:0]       match_len     [NumKeys];
  phase_e           lane_phase    [NumKeys];
  logic [1:0]       octet_idx     [NumKeys];
  logic [7:0]       octet_val     [NumKeys];
  logic             octet_seen    [NumKeys];
  logic [AddrW-1:0] addr_acc      [NumKeys];
  logic             addr_ok       [NumKeys];
  addr_set_t        addr_expect_q [$];

  function automatic logic [7:0] key_char_at(int k, int pos);
    return KeyText[k][(int'(KeyLen[k]) - 1 - pos) * 8 +: 8];
  endfunction

  task automatic clear_lanes();
    for (int k = 0; k < NumKeys; k++) begin
      match_len[k]  = '0;
      lane_phase[k] = PH_SEARCH;
      octet_idx[k]  = '0;
      octet_val[k]  = '0;
      octet_seen[k] = 1'b0;
      addr_acc[k]   = '0;
      addr_ok[k]    = 1'b0;
    end
  endtask

  task automatic seal_lane(int k, logic ok);
    lane_phase[k] = PH_DONE;
    addr_ok[k]    = ok;
    if (ok) addr_acc[k] = {addr_acc[k][AddrW-9:0], octet_val[k]};
  endtask

  task automatic scan_char(int k, logic [7:0] c);
    int         digit_sum;
    logic [2:0] pos;
    case (lane_phase[k])
      PH_SEARCH: begin
        pos = match_len[k];
        // no key repeats its lead character, so a miss restarts at 0 or 1
        if (pos < KeyLen[k] && c == key_char_at(k, pos)) pos = pos + 3'd1;
        else if (c == key_char_at(k, 0)) pos = 3'd1;
        else pos = 3'd0;
        match_len[k] = pos;
        if (pos == KeyLen[k]) begin
          lane_phase[k] = PH_PARSE;
          octet_idx[k]  = '0;
          octet_val[k]  = '0;
          octet_seen[k] = 1'b0;
          addr_acc[k]   = '0;
        end
      end
      PH_PARSE: begin
        if (c >= CharZero && c <= CharNine) begin
          digit_sum = int'(octet_val[k]) * 10 + int'(c) - int'(CharZero);
          if (digit_sum > OctetMax) begin
            seal_lane(k, 1'b0);
          end else begin
            octet_val[k]  = digit_sum[7:0];
            octet_seen[k] = 1'b1;
          end
        end else if (!octet_seen[k]) begin
          seal_lane(k, 1'b0);
        end else if (octet_idx[k] == 2'd3) begin
          seal_lane(k, 1'b1);
        end else if (c != CharDot) begin
          seal_lane(k, 1'b0);
        end else begin
          addr_acc[k]   = {addr_acc[k][AddrW-9:0], octet_val[k]};
          octet_idx[k]  = octet_idx[k] + 2'd1;
          octet_val[k]  = '0;
          octet_seen[k] = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic close_line();
    addr_set_t        res;
    logic [AddrW-1:0] pick [NumKeys];
    for (int k = 0; k < NumKeys; k++) begin
      if (lane_phase[k] == PH_PARSE) seal_lane(k, octet_idx[k] == 2'd3 && octet_seen[k]);
      pick[k] = addr_ok[k] ? addr_acc[k] : fallback_addr[k];
    end
    res.ip   = pick[KEY_IP];
    res.mask = pick[KEY_MASK];
    res.gw   = pick[KEY_GW];
    addr_expect_q.push_back(res);
    clear_lanes();
  endtask

  task automatic check_field(string name, logic [AddrW-1:0] want, logic [AddrW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %08h, got %08h", $time, name, want, got);
      mismatch_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    addr_set_t want;
    if (!rst_ni) begin
      fallback_addr[KEY_IP]   = DefaultIpReset;
      fallback_addr[KEY_MASK] = DefaultMaskReset;
      fallback_addr[KEY_GW]   = DefaultGwReset;
      clear_lanes();
      addr_expect_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (addr_expect_q.size() == 0) begin
          $display("%0t: unexpected address set: expected none, got %08h %08h %08h",
                   $time, ip_address_i, net_mask_i, gateway_address_i);
          mismatch_cnt_o++;
        end else begin
          want = addr_expect_q.pop_front();
          check_field("ip_address", want.ip, ip_address_i);
          check_field("net_mask", want.mask, net_mask_i);
          check_field("gateway_address", want.gw, gateway_address_i);
          addr_sets_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgDefaultIp:   fallback_addr[KEY_IP]   = cfg_data_i;
          CfgDefaultMask: fallback_addr[KEY_MASK] = cfg_data_i;
          CfgDefaultGw:   fallback_addr[KEY_GW]   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        chars_o++;
        for (int k = 0; k < NumKeys; k++) scan_char(k, char_code_i);
        if (last_i) close_line();
      end
      pending_o = addr_expect_q.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cikp_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned CharBudget = 1950;
  localparam int          NumPhases  = 6;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic [CharW-1:0]   char_code = '0;
  logic               last      = 1'b0;
  logic               out_ready = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [AddrW-1:0]   cfg_data  = '0;

  logic             in_ready;
  logic             out_valid;
  logic             cfg_ready;
  logic [AddrW-1:0] ip_address;
  logic [AddrW-1:0] net_mask;
  logic [AddrW-1:0] gateway_address;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned addr_sets;
  int unsigned chars_seen;

  int unsigned tx_idle_pct  = 20;
  int unsigned rx_idle_pct  = 10;
  int unsigned rx_hold      = 0;
  int unsigned quiet_cycles = 0;
  int unsigned chars_sent   = 0;
  logic [7:0]  line_q [$];

  always #10 clk_i = ~clk_i;

  cmdline_ipv4_key_parser i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .char_code_i       (char_code),
    .last_i            (last),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .ip_address_o      (ip_address),
    .net_mask_o        (net_mask),
    .gateway_address_o (gateway_address),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  key_parser_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .char_code_i       (char_code),
    .last_i            (last),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .ip_address_i      (ip_address),
    .net_mask_i        (net_mask),
    .gateway_address_i (gateway_address),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .mismatch_cnt_o    (mismatch_cnt),
    .pending_o         (pending_cnt),
    .addr_sets_o       (addr_sets),
    .chars_o           (chars_seen)
  );

  // Stall the result side in bursts at random
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_pct != 0 && $urandom_range(99, 0) < rx_idle_pct) begin
      rx_hold   <= $urandom_range(8, 0);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, StallLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic is_last);
    if (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last      <= is_last;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_char(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic push_number(input int v);
    push_text($sformatf("%0d", v));
  endtask

  function automatic logic [7:0] noise_char();
    string       pool;
    int unsigned pick;
    pool = " .=,:/-0123456789ipmaskgw";
    pick = $urandom_range(15, 0);
    if (pick == 0) return 8'h00;
    if (pick < 7) return 8'($urandom_range(255, 0));
    return pool[$urandom_range(pool.len() - 1, 0)];
  endfunction

  task automatic add_octet();
    case ($urandom_range(19, 0))
      0: ;
      1: push_number($urandom_range(999, 256));
      2: push_number($urandom_range(9999, 1000));
      3: begin
        repeat ($urandom_range(3, 1)) line_q.push_back(CharZero);
        push_number($urandom_range(255, 0));
      end
      4: push_number(255);
      5: push_number(0);
      default: push_number($urandom_range(255, 0));
    endcase
  endtask

  task automatic add_key_entry();
    key_e        which;
    string       word;
    int unsigned shape;
    int unsigned octets;
    int unsigned cut;
    which = key_e'($urandom_range(2, 0));
    case (which)
      KEY_IP:   word = "ip=";
      KEY_MASK: word = "mask=";
      default:  word = "gw=";
    endcase
    shape = $urandom_range(9, 0);
    if (shape == 0) begin
      // broken key: a prefix followed by a stray character
      cut = $urandom_range(word.len() - 1, 1);
      for (int i = 0; i < cut; i++) line_q.push_back(word[i]);
      line_q.push_back(noise_char());
    end else begin
      // doubled lead character exercises the restart of the match
      if (shape == 1) line_q.push_back(word[0]);
      push_text(word);
      octets = ($urandom_range(3, 0) == 0) ? $urandom_range(5, 1) : 4;
      for (int o = 0; o < octets; o++) begin
        add_octet();
        if (o < octets - 1) line_q.push_back(($urandom_range(9, 0) == 0) ? noise_char() : CharDot);
      end
      if ($urandom_range(1, 0) == 1) line_q.push_back(noise_char());
    end
  endtask

  task automatic build_line();
    int unsigned segs;
    segs = $urandom_range(4, 1);
    for (int s = 0; s < segs; s++) begin
      if ($urandom_range(9, 0) < 3) begin
        repeat ($urandom_range(4, 0)) line_q.push_back(noise_char());
      end else begin
        add_key_entry();
      end
    end
    if (line_q.size() == 0) line_q.push_back(noise_char());
  endtask

  task automatic write_fallback(input logic [CfgIdxW-1:0] idx, input logic [AddrW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold off until every address set is out, then let the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int unsigned idle_pick();
    case ($urandom_range(3, 0))
      0:       return 0;
      1:       return 5;
      2:       return 15;
      default: return 40;
    endcase
  endfunction

  initial begin
    int unsigned target;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short directed strings under the reset defaults
    send_char(8'hFF, 1'b1);
    push_text("ip=");
    send_line();
    push_text("gw=255.0.00.9 ");
    send_line();
    push_text("mask=256");
    send_line();

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          write_fallback(CfgDefaultIp, '0);
          write_fallback(CfgDefaultMask, '0);
          write_fallback(CfgDefaultGw, '0);
        end
        1: begin
          write_fallback(CfgDefaultIp, '1);
          write_fallback(CfgDefaultMask, '1);
          write_fallback(CfgDefaultGw, '1);
        end
        default: begin
          write_fallback(CfgDefaultIp, $urandom());
          write_fallback(CfgDefaultMask, $urandom());
          write_fallback(CfgDefaultGw, $urandom());
          // unmapped index must leave all defaults alone
          write_fallback(CfgSpare, $urandom());
        end
      endcase
      if (ph < NumPhases - 2) begin
        tx_idle_pct = idle_pick();
        rx_idle_pct = idle_pick();
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      target = CharBudget * (ph + 1) / NumPhases;
      while (chars_sent < target) begin
        build_line();
        send_line();
      end
    end
    wait_drained();

    $display("Covered %0d characters and %0d address sets across reset, zero, all-one",
             chars_seen, addr_sets);
    $display("and random default settings, with and without flow-control gaps.");
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
